// File: rtl/core/htx_pkg.sv
// ----------------------------------------------------------------------------
// htx_pkg
// Shared types and defaults for the handshake transcript extractor.
// ----------------------------------------------------------------------------
package htx_pkg;

  localparam int unsigned MAX_MESSAGES_DEF = 16;

  // one result as it leaves the block
  typedef struct packed {
    logic        result_kind;
    logic [7:0]  msg_type;
    logic [31:0] msg_offset;
    logic [15:0] msg_length;
    logic [7:0]  msg_slot;
    logic        parse_status;
    logic [31:0] byte_total;
    logic [7:0]  entry_count;
    logic        truncated;
    logic        last_of_run;
  } result_t;

  // what one parse step hands to the result buffer
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } step_t;

endpackage

// File: rtl/core/handshake_transcript_extractor_core.sv
// ----------------------------------------------------------------------------
// handshake_transcript_extractor_core
// TLS record deframer that reports handshake messages and a buffer status.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one stream byte per request, with
// end_of_buffer on the final byte of a buffer.
// Output channel (out_valid/out_ready): one result per request; a byte
// causes none, one message entry, one status, or an entry then a status.
// last_of_run marks the final result caused by a byte.
// Throughput: one byte per cycle while results flow; a byte that causes two
// results holds the output port for both, one after the other, out of the
// two-entry result queue. A taken byte passes the input register, then the
// result queue, before its first result is offered. keep_finished is written
// over the APB port at address 0, by the user only while idle; not enforced.
// Reset clears the framing state, the queue and keep_finished; the block
// takes bytes from the first cycle after reset. A stalled receiver fills
// the two-entry queue, after which in_ready drops until it drains.
// ----------------------------------------------------------------------------
module handshake_transcript_extractor_core #(
  parameter int unsigned MAX_MESSAGES = htx_pkg::MAX_MESSAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_buffer,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [7:0]  msg_type,
  output logic [31:0] msg_offset,
  output logic [15:0] msg_length,
  output logic [7:0]  msg_slot,
  output logic        parse_status,
  output logic [31:0] byte_total,
  output logic [7:0]  entry_count,
  output logic        truncated,
  output logic        last_of_run
);

  logic             keep_finished;
  logic             in_full;
  logic             advance;
  logic [1:0]       free;
  htx_pkg::step_t   step;
  htx_pkg::step_t   push;
  htx_pkg::result_t res;

  htx_apb_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .keep_finished (keep_finished)
  );

  htx_parser #(
    .MAX_MESSAGES (MAX_MESSAGES)
  ) u_parser (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .end_of_buffer (end_of_buffer),
    .keep_finished (keep_finished),
    .advance       (advance),
    .in_full       (in_full),
    .step          (step)
  );

  // a byte moves on only when the queue has room for all it produces
  assign advance = in_full && (step.count <= free);

  always_comb begin
    push       = step;
    push.count = advance ? step.count : 2'd0;
  end

  htx_result_buf u_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head_res  (res)
  );

  assign result_kind  = res.result_kind;
  assign msg_type     = res.msg_type;
  assign msg_offset   = res.msg_offset;
  assign msg_length   = res.msg_length;
  assign msg_slot     = res.msg_slot;
  assign parse_status = res.parse_status;
  assign byte_total   = res.byte_total;
  assign entry_count  = res.entry_count;
  assign truncated    = res.truncated;
  assign last_of_run  = res.last_of_run;

endmodule

// File: rtl/core/htx_apb_regs.sv
// ----------------------------------------------------------------------------
// htx_apb_regs
// Configuration register file: keep_finished at byte address 0.
// ----------------------------------------------------------------------------
module htx_apb_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        keep_finished
);

  localparam logic REG_KEEP_FINISHED = 1'b0;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_KEEP_FINISHED);

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_finished <= 1'b0;
    end else if (wr_en) begin
      keep_finished <= pwdata[0];
    end
  end

  // paddr[1:0] select a byte within the word and are ignored
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_KEEP_FINISHED) begin
      prdata = {31'd0, keep_finished};
    end
  end

endmodule

// File: rtl/core/htx_parser.sv
// ----------------------------------------------------------------------------
// htx_parser
// Input register and record/handshake framing state; one byte per step.
// ----------------------------------------------------------------------------
module htx_parser #(
  parameter int unsigned MAX_MESSAGES = htx_pkg::MAX_MESSAGES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    data_byte,
  input  logic          end_of_buffer,
  input  logic          keep_finished,
  input  logic          advance,
  output logic          in_full,
  output htx_pkg::step_t step
);

  localparam logic [2:0] PH_RECORD    = 3'd0;
  localparam logic [2:0] PH_SKIP      = 3'd1;
  localparam logic [2:0] PH_HS_HEADER = 3'd2;
  localparam logic [2:0] PH_HS_BODY   = 3'd3;
  localparam logic [2:0] PH_DRAIN     = 3'd4;

  localparam logic [7:0] TYPE_HANDSHAKE = 8'd22;
  localparam logic [7:0] TYPE_FINISHED  = 8'd20;
  localparam logic [7:0] MAX_SLOTS      = 8'(MAX_MESSAGES);

  // input register
  logic       in_byte_is;
  logic [7:0] in_byte;
  logic       in_eob;

  // framing state
  logic [2:0]  phase,      phase_next;
  logic [2:0]  hdr_idx,    hdr_idx_next;
  logic        is_hs,      is_hs_next;
  logic [15:0] rec_rem,    rec_rem_next;
  logic [7:0]  hs_type,    hs_type_next;
  logic [23:0] hs_len,     hs_len_next;
  logic [15:0] body_rem,   body_rem_next;
  logic [31:0] offset,     offset_next;
  logic [31:0] msg_start,  msg_start_next;
  logic [31:0] kept,       kept_next;
  logic [7:0]  stored,     stored_next;
  logic        trunc,      trunc_next;
  logic        err,        err_next;

  logic [15:0] rec_dec;
  logic [15:0] rec_full;
  logic [15:0] body_dec;
  logic [31:0] mlen;
  logic [32:0] kept_sum;
  logic        entry_valid;
  logic        status_bad;
  logic [31:0] stat_kept;
  logic [7:0]  stat_count;
  logic        stat_trunc;
  htx_pkg::result_t entry;
  htx_pkg::result_t status;

  // phase once a message (or record header) is done
  function automatic logic [2:0] after_msg(input logic [15:0] rem);
    logic [2:0] ph;
    if (rem == 16'd0) begin
      ph = PH_RECORD;
    end else if (rem < 16'd4) begin
      ph = PH_DRAIN;
    end else begin
      ph = PH_HS_HEADER;
    end
    return ph;
  endfunction

  assign in_full    = in_byte_is;
  assign in_ready   = !in_byte_is || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_byte_is <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_byte_is <= 1'b1;
    end else if (advance) begin
      in_byte_is <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= data_byte;
      in_eob  <= end_of_buffer;
    end
  end

  assign rec_dec  = (rec_rem != 16'd0) ? rec_rem - 16'd1 : 16'd0;
  assign body_dec = (body_rem != 16'd0) ? body_rem - 16'd1 : 16'd0;
  assign rec_full = {rec_rem[15:8], in_byte};

  always_comb begin
    phase_next     = phase;
    hdr_idx_next   = hdr_idx;
    is_hs_next     = is_hs;
    rec_rem_next   = rec_rem;
    hs_type_next   = hs_type;
    hs_len_next    = hs_len;
    body_rem_next  = body_rem;
    offset_next    = offset + 32'd1;
    msg_start_next = msg_start;
    kept_next      = kept;
    stored_next    = stored;
    trunc_next     = trunc;
    err_next       = err;
    entry_valid    = 1'b0;
    mlen           = 32'd0;
    kept_sum       = 33'd0;

    case (phase)
      PH_RECORD: begin
        if (hdr_idx == 3'd0) begin
          is_hs_next = (in_byte == TYPE_HANDSHAKE);
        end else if (hdr_idx == 3'd3) begin
          rec_rem_next = {in_byte, 8'd0};
        end else if (hdr_idx == 3'd4) begin
          rec_rem_next = rec_full;
        end
        if (hdr_idx >= 3'd4) begin
          hdr_idx_next = 3'd0;
          if (rec_full == 16'd0) begin
            phase_next = PH_RECORD;
          end else if (is_hs) begin
            phase_next = after_msg(rec_full);
          end else begin
            phase_next = PH_SKIP;
          end
        end else begin
          hdr_idx_next = hdr_idx + 3'd1;
        end
      end
      PH_SKIP: begin
        rec_rem_next = rec_dec;
        if (rec_dec == 16'd0) begin
          phase_next = PH_RECORD;
        end
      end
      PH_HS_HEADER: begin
        rec_rem_next = rec_dec;
        if (hdr_idx == 3'd0) begin
          msg_start_next = offset;
          hs_type_next   = in_byte;
          hs_len_next    = 24'd0;
        end else begin
          hs_len_next = {hs_len[15:0], in_byte};
        end
        if (hdr_idx >= 3'd3) begin
          hdr_idx_next = 3'd0;
          if (hs_len_next > {8'd0, rec_dec}) begin
            phase_next = PH_DRAIN;
          end else begin
            if (keep_finished || (hs_type != TYPE_FINISHED)) begin
              mlen     = {8'd0, hs_len_next} + 32'd4;
              kept_sum = {1'b0, kept} + {1'b0, mlen};
              if (kept_sum[32]) begin
                kept_next  = '1;
                trunc_next = 1'b1;
              end else begin
                kept_next = kept_sum[31:0];
              end
              if (stored < MAX_SLOTS) begin
                entry_valid = 1'b1;
                stored_next = stored + 8'd1;
              end else begin
                trunc_next = 1'b1;
              end
            end
            body_rem_next = hs_len_next[15:0];
            if (hs_len_next[15:0] == 16'd0) begin
              phase_next = after_msg(rec_dec);
            end else begin
              phase_next = PH_HS_BODY;
            end
          end
        end else begin
          hdr_idx_next = hdr_idx + 3'd1;
        end
      end
      PH_HS_BODY: begin
        rec_rem_next  = rec_dec;
        body_rem_next = body_dec;
        if (body_dec == 16'd0) begin
          hdr_idx_next = 3'd0;
          phase_next   = after_msg(rec_dec);
        end
      end
      default: begin
      end
    endcase

    if (phase_next == PH_DRAIN) begin
      err_next = 1'b1;
    end

    status_bad = err_next || (phase_next != PH_RECORD) || (hdr_idx_next != 3'd0);

    // counters as they stand after this byte, before the end-of-buffer clear
    stat_kept  = kept_next;
    stat_count = stored_next;
    stat_trunc = trunc_next;

    // end of buffer: status goes out, framing starts afresh
    if (in_eob) begin
      phase_next     = PH_RECORD;
      hdr_idx_next   = 3'd0;
      is_hs_next     = 1'b0;
      rec_rem_next   = 16'd0;
      hs_type_next   = 8'd0;
      hs_len_next    = 24'd0;
      body_rem_next  = 16'd0;
      offset_next    = 32'd0;
      msg_start_next = 32'd0;
      kept_next      = 32'd0;
      stored_next    = 8'd0;
      trunc_next     = 1'b0;
      err_next       = 1'b0;
    end
  end

  always_comb begin
    entry              = '0;
    entry.msg_type     = hs_type;
    entry.msg_offset   = msg_start;
    entry.msg_length   = mlen[15:0];
    entry.msg_slot     = stored;
    entry.last_of_run  = !in_eob;

    status              = '0;
    status.result_kind  = 1'b1;
    status.parse_status = status_bad;
    status.byte_total   = stat_kept;
    status.entry_count  = stat_count;
    status.truncated    = stat_trunc;
    status.last_of_run  = 1'b1;

    step.count  = {1'b0, entry_valid} + {1'b0, in_eob};
    step.first  = entry_valid ? entry : status;
    step.second = status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_RECORD;
      hdr_idx   <= 3'd0;
      is_hs     <= 1'b0;
      rec_rem   <= 16'd0;
      hs_type   <= 8'd0;
      hs_len    <= 24'd0;
      body_rem  <= 16'd0;
      offset    <= 32'd0;
      msg_start <= 32'd0;
      kept      <= 32'd0;
      stored    <= 8'd0;
      trunc     <= 1'b0;
      err       <= 1'b0;
    end else if (advance) begin
      phase     <= phase_next;
      hdr_idx   <= hdr_idx_next;
      is_hs     <= is_hs_next;
      rec_rem   <= rec_rem_next;
      hs_type   <= hs_type_next;
      hs_len    <= hs_len_next;
      body_rem  <= body_rem_next;
      offset    <= offset_next;
      msg_start <= msg_start_next;
      kept      <= kept_next;
      stored    <= stored_next;
      trunc     <= trunc_next;
      err       <= err_next;
    end
  end

endmodule

// File: rtl/core/htx_result_buf.sv
// ----------------------------------------------------------------------------
// htx_result_buf
// Two-entry result queue; takes up to two results a cycle, gives one.
// ----------------------------------------------------------------------------
module htx_result_buf (
  input  logic             clk,
  input  logic             rst,
  input  htx_pkg::step_t   push,
  output logic [1:0]       free,
  output logic             out_valid,
  input  logic             out_ready,
  output htx_pkg::result_t head_res
);

  htx_pkg::result_t head, head_next;
  htx_pkg::result_t tail, tail_next;
  logic [1:0] count, count_next;
  logic [1:0] cnt_pop;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && out_ready;
  assign cnt_pop   = pop ? count - 2'd1 : count;
  assign free      = 2'd2 - cnt_pop;
  assign head_res  = head;

  always_comb begin
    head_next  = pop ? tail : head;
    tail_next  = tail;
    if (push.count != 2'd0) begin
      if (cnt_pop == 2'd0) begin
        head_next = push.first;
        if (push.count == 2'd2) begin
          tail_next = push.second;
        end
      end else begin
        tail_next = push.first;
      end
    end
    count_next = cnt_pop + push.count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    head <= head_next;
    tail <= tail_next;
  end

endmodule

// File: bench/tb_handshake_transcript_extractor_core.sv
// ----------------------------------------------------------------------------
// tb_handshake_transcript_extractor_core
// Self-checking bench for the TLS record deframer and transcript extractor.
// A directed table covers cut-short buffers, skipped Finished messages, short
// leftovers and oversized messages. Random buffers of well-formed records
// follow, with some noise and damage mixed in. Each result is checked against
// a behavioural deframer in the bench, or against a status typed into the table.
// ----------------------------------------------------------------------------
module tb_handshake_transcript_extractor_core;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    PH_RECORD, PH_SKIP, PH_HS_HEADER, PH_HS_BODY, PH_DRAIN
  } frame_phase_t;

  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY} stall_mode_t;

  localparam logic [2:0] REG_KEEP_FINISHED = 3'd0;
  localparam logic [7:0] CT_HANDSHAKE = 8'd22;
  localparam logic [7:0] HS_FINISHED = 8'd20;
  localparam int MAX_SLOTS = htx_pkg::MAX_MESSAGES_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES = 240;
  localparam int DRAIN_CYCLES = 6;
  localparam int BYTES_PER_PHASE = 470;

  // status typed in by hand for a request; typed = 0 leaves it to the deframer
  typedef struct packed {
    logic        typed;
    logic        st;
    logic [31:0] bytes;
    logic [7:0]  cnt;
    logic        tr;
  } status_note_t;

  typedef struct packed {
    logic [7:0]   data;
    logic         eob;
    status_note_t note;
  } dir_row_t;

  localparam status_note_t NO_NOTE = '0;

  dir_row_t dir_tab [28] = '{
    // one byte then end of buffer: record header cut short
    '{8'hFF, 1'b1, '{1'b1, 1'b1, 32'd0, 8'd0, 1'b0}},
    // handshake record: an 0xFF message, then a Finished which is skipped
    '{8'h16, 1'b0, NO_NOTE}, '{8'h03, 1'b0, NO_NOTE}, '{8'h03, 1'b0, NO_NOTE},
    '{8'h00, 1'b0, NO_NOTE}, '{8'h08, 1'b0, NO_NOTE},
    '{8'hFF, 1'b0, NO_NOTE}, '{8'h00, 1'b0, NO_NOTE}, '{8'h00, 1'b0, NO_NOTE},
    '{8'h00, 1'b0, NO_NOTE},
    '{8'h14, 1'b0, NO_NOTE}, '{8'h00, 1'b0, NO_NOTE}, '{8'h00, 1'b0, NO_NOTE},
    '{8'h00, 1'b1, '{1'b1, 1'b0, 32'd4, 8'd1, 1'b0}},
    // two-byte handshake record: too short for a message header
    '{8'h16, 1'b0, NO_NOTE}, '{8'hFF, 1'b0, NO_NOTE}, '{8'hFF, 1'b0, NO_NOTE},
    '{8'h00, 1'b0, NO_NOTE},
    '{8'h02, 1'b1, '{1'b1, 1'b1, 32'd0, 8'd0, 1'b0}},
    // message body longer than what is left of the record
    '{8'h16, 1'b0, NO_NOTE}, '{8'h00, 1'b0, NO_NOTE}, '{8'h00, 1'b0, NO_NOTE},
    '{8'h00, 1'b0, NO_NOTE}, '{8'h04, 1'b0, NO_NOTE},
    '{8'h02, 1'b0, NO_NOTE}, '{8'h00, 1'b0, NO_NOTE}, '{8'h00, 1'b0, NO_NOTE},
    '{8'h05, 1'b1, '{1'b1, 1'b1, 32'd0, 8'd0, 1'b0}}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        end_of_buffer = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic        result_kind;
  logic [7:0]  msg_type;
  logic [31:0] msg_offset;
  logic [15:0] msg_length;
  logic [7:0]  msg_slot;
  logic        parse_status;
  logic [31:0] byte_total;
  logic [7:0]  entry_count;
  logic        truncated;
  logic        last_of_run;

  handshake_transcript_extractor_core dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_ready, .data_byte, .end_of_buffer,
    .out_valid, .out_ready, .result_kind, .msg_type, .msg_offset, .msg_length,
    .msg_slot, .parse_status, .byte_total, .entry_count, .truncated,
    .last_of_run
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---- deframer state --------------------------------------------------
  logic         keep_fin_cfg = 1'b0;
  frame_phase_t f_phase;
  logic [2:0]   f_hidx;
  logic         f_is_hs;
  logic [15:0]  f_rec_left;
  logic [7:0]   f_hs_type;
  logic [23:0]  f_hs_len;
  logic [15:0]  f_body_left;
  logic [31:0]  f_offset;
  logic [31:0]  f_msg_start;
  logic [31:0]  f_kept;
  logic [7:0]   f_stored;
  logic         f_trunc;
  logic         f_err;

  htx_pkg::result_t step_res[$];
  htx_pkg::result_t pending_results[$];
  status_note_t     note_q[$];
  logic [7:0]       buf_bytes[$];
  int               mismatch_count = 0;

  function automatic void clear_framing();
    f_phase = PH_RECORD;
    f_hidx = '0;
    f_is_hs = 1'b0;
    f_rec_left = '0;
    f_hs_type = '0;
    f_hs_len = '0;
    f_body_left = '0;
    f_offset = '0;
    f_msg_start = '0;
    f_kept = '0;
    f_stored = '0;
    f_trunc = 1'b0;
    f_err = 1'b0;
  endfunction

  function automatic void framing_error();
    f_err = 1'b1;
    f_phase = PH_DRAIN;
  endfunction

  // what follows a finished message: next record, next header, or a short tail
  function automatic void close_message();
    f_hidx = '0;
    if (f_rec_left == 0) f_phase = PH_RECORD;
    else if (f_rec_left < 4) framing_error();
    else f_phase = PH_HS_HEADER;
  endfunction

  function automatic void deframe_byte(input logic [7:0] b, input logic eob);
    logic [31:0]      off;
    logic [31:0]      mlen;
    htx_pkg::result_t r;
    step_res.delete();
    off = f_offset;
    f_offset = off + 32'd1;
    case (f_phase)
      PH_RECORD: begin
        if (f_hidx == 0) f_is_hs = (b == CT_HANDSHAKE);
        else if (f_hidx == 3) f_rec_left = {b, 8'h00};
        else if (f_hidx == 4) f_rec_left = f_rec_left | {8'h00, b};
        if (f_hidx >= 4) begin
          f_hidx = '0;
          if (f_rec_left == 0) f_phase = PH_RECORD;
          else if (f_is_hs) close_message();
          else f_phase = PH_SKIP;
        end else begin
          f_hidx = f_hidx + 3'd1;
        end
      end
      PH_SKIP: begin
        if (f_rec_left != 0) f_rec_left = f_rec_left - 16'd1;
        if (f_rec_left == 0) f_phase = PH_RECORD;
      end
      PH_HS_HEADER: begin
        if (f_rec_left != 0) f_rec_left = f_rec_left - 16'd1;
        if (f_hidx == 0) begin
          f_msg_start = off;
          f_hs_type = b;
          f_hs_len = '0;
        end else begin
          f_hs_len = {f_hs_len[15:0], b};
        end
        if (f_hidx >= 3) begin
          f_hidx = '0;
          if (f_hs_len > {8'h00, f_rec_left}) begin
            framing_error();
          end else begin
            if (keep_fin_cfg || f_hs_type != HS_FINISHED) begin
              mlen = {8'h00, f_hs_len} + 32'd4;
              if (mlen > 32'hFFFF_FFFF - f_kept) begin
                f_kept = 32'hFFFF_FFFF;
                f_trunc = 1'b1;
              end else begin
                f_kept = f_kept + mlen;
              end
              if (f_stored < MAX_SLOTS) begin
                r = '0;
                r.msg_type = f_hs_type;
                r.msg_offset = f_msg_start;
                r.msg_length = mlen[15:0];
                r.msg_slot = f_stored;
                step_res.push_back(r);
                f_stored = f_stored + 8'd1;
              end else begin
                f_trunc = 1'b1;
              end
            end
            f_body_left = f_hs_len[15:0];
            if (f_body_left == 0) close_message();
            else f_phase = PH_HS_BODY;
          end
        end else begin
          f_hidx = f_hidx + 3'd1;
        end
      end
      PH_HS_BODY: begin
        if (f_rec_left != 0) f_rec_left = f_rec_left - 16'd1;
        if (f_body_left != 0) f_body_left = f_body_left - 16'd1;
        if (f_body_left == 0) close_message();
      end
      default: ;
    endcase
    if (eob) begin
      r = '0;
      r.result_kind = 1'b1;
      r.parse_status = f_err || f_phase != PH_RECORD || f_hidx != 0;
      r.byte_total = f_kept;
      r.entry_count = f_stored;
      r.truncated = f_trunc;
      step_res.push_back(r);
      clear_framing();
    end
    if (step_res.size() != 0) step_res[step_res.size() - 1].last_of_run = 1'b1;
  endfunction

  function automatic string fmt_result(htx_pkg::result_t r);
    return $sformatf({"kind=%0d type=%h off=%h len=%h slot=%0d st=%0d",
                      " bytes=%h cnt=%0d tr=%0d last=%0d"},
                     r.result_kind, r.msg_type, r.msg_offset, r.msg_length, r.msg_slot,
                     r.parse_status, r.byte_total, r.entry_count, r.truncated,
                     r.last_of_run);
  endfunction

  function automatic void check_result(htx_pkg::result_t got);
    htx_pkg::result_t want;
    if (pending_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("[%0t] result with nothing expected: %s", $realtime, fmt_result(got));
      return;
    end
    want = pending_results.pop_front();
    if (got.result_kind !== want.result_kind || got.msg_type !== want.msg_type ||
        got.msg_offset !== want.msg_offset || got.msg_length !== want.msg_length ||
        got.msg_slot !== want.msg_slot || got.parse_status !== want.parse_status ||
        got.byte_total !== want.byte_total ||
        got.entry_count !== want.entry_count || got.truncated !== want.truncated ||
        got.last_of_run !== want.last_of_run) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("[%0t] result mismatch", $realtime);
        $display("  exp %s", fmt_result(want));
        $display("  got %s", fmt_result(got));
      end
    end
  endfunction

  // output checked before the input is folded in, so the order is fixed
  always @(posedge clk) begin
    status_note_t     note;
    htx_pkg::result_t r;
    if (!rst) begin
      if (out_valid && out_ready)
        check_result({result_kind, msg_type, msg_offset, msg_length, msg_slot, parse_status,
                      byte_total, entry_count, truncated, last_of_run});
      if (in_valid && in_ready) begin
        note = note_q.pop_front();
        deframe_byte(data_byte, end_of_buffer);
        if (note.typed) begin
          r = '0;
          r.result_kind = 1'b1;
          r.parse_status = note.st;
          r.byte_total = note.bytes;
          r.entry_count = note.cnt;
          r.truncated = note.tr;
          r.last_of_run = 1'b1;
          pending_results.push_back(r);
        end else begin
          foreach (step_res[i]) pending_results.push_back(step_res[i]);
        end
      end
    end
  end

  // ---- receiver: stall pattern plus a long hold on request ----------------
  logic [3:0]  hold_ticket = '0;
  logic [3:0]  hold_seen = '0;
  int          hold_left = 0;
  stall_mode_t rx_mode = RX_OPEN;
  int          rx_stretch = 0;

  always @(posedge clk) begin
    if (hold_ticket != hold_seen) begin
      hold_seen <= hold_ticket;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (rx_stretch == 0) begin
        rx_mode <= stall_mode_t'($urandom_range(0, 2));
        rx_stretch <= $urandom_range(20, 120);
      end else begin
        rx_stretch <= rx_stretch - 1;
      end
      case (rx_mode)
        RX_OPEN:  out_ready <= 1'b1;
        RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
        default:  out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // ---- watchdog ------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---- sender ----------------------------------------------------------------
  int burst_left = 0;

  task automatic send_byte(input logic [7:0] b, input logic eob);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 24);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    data_byte <= b;
    end_of_buffer <= eob;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == REG_KEEP_FINISHED) keep_fin_cfg = value[0];
  endtask

  // wait for every expected result, then for anything still in flight
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic void push_record_header(input logic [7:0] ctype, input logic [15:0] len);
    buf_bytes.push_back(ctype);
    buf_bytes.push_back(8'($urandom));
    buf_bytes.push_back(8'($urandom));
    buf_bytes.push_back(len[15:8]);
    buf_bytes.push_back(len[7:0]);
  endfunction

  // mostly well-formed records with random content; some noise and damage
  function automatic void compose_buffer();
    int         nrec;
    int         nmsg;
    int         sel;
    int         blen;
    int         total;
    int         idx;
    logic [7:0] mtype;
    int         lens[$];
    logic [7:0] types[$];
    buf_bytes.delete();
    if ($urandom_range(0, 99) < 6) begin
      repeat ($urandom_range(1, 16)) buf_bytes.push_back(8'($urandom));
      return;
    end
    nrec = $urandom_range(1, 3);
    repeat (nrec) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        lens.delete();
        types.delete();
        total = 0;
        // now and then enough messages to run out of slots
        nmsg = ($urandom_range(0, 99) < 8) ? $urandom_range(17, 22) : $urandom_range(0, 3);
        repeat (nmsg) begin
          if (nmsg > MAX_SLOTS) blen = 0;
          else if ($urandom_range(0, 99) < 3) blen = $urandom_range(200, 400);
          else blen = $urandom_range(0, 8);
          mtype = ($urandom_range(0, 4) == 0) ? HS_FINISHED : 8'($urandom_range(0, 255));
          lens.push_back(blen);
          types.push_back(mtype);
          total += 4 + blen;
        end
        push_record_header(CT_HANDSHAKE, total[15:0]);
        foreach (lens[i]) begin
          buf_bytes.push_back(types[i]);
          buf_bytes.push_back(8'h00);
          buf_bytes.push_back(lens[i][15:8]);
          buf_bytes.push_back(lens[i][7:0]);
          repeat (lens[i]) buf_bytes.push_back(8'($urandom));
        end
      end else if (sel < 80) begin
        push_record_header(8'($urandom), 16'd0);
      end else begin
        mtype = 8'($urandom_range(0, 255));
        if (mtype == CT_HANDSHAKE) mtype = 8'd23;
        blen = ($urandom_range(0, 19) == 0) ? $urandom_range(256, 300) : $urandom_range(0, 10);
        push_record_header(mtype, blen[15:0]);
        repeat (blen) buf_bytes.push_back(8'($urandom));
      end
    end
    if ($urandom_range(0, 99) < 18) begin
      case ($urandom_range(0, 2))
        0: begin
          idx = $urandom_range(1, buf_bytes.size());
          while (buf_bytes.size() > idx) void'(buf_bytes.pop_back());
        end
        1: begin
          idx = $urandom_range(0, buf_bytes.size() - 1);
          buf_bytes[idx] = 8'($urandom);
        end
        default: repeat ($urandom_range(1, 6)) buf_bytes.push_back(8'($urandom));
      endcase
    end
  endfunction

  initial begin
    int  phase_sent;
    logic hold_done;
    clear_framing();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(REG_KEEP_FINISHED, 32'd0);
    foreach (dir_tab[i]) begin
      note_q.push_back(dir_tab[i].note);
      send_byte(dir_tab[i].data, dir_tab[i].eob);
    end
    drain_block();

    hold_done = 1'b0;
    for (int ph = 0; ph < 3; ph++) begin
      write_reg(REG_KEEP_FINISHED, (ph == 1) ? 32'd0 : 32'd1);
      phase_sent = 0;
      while (phase_sent < BYTES_PER_PHASE) begin
        if (ph == 1 && !hold_done && phase_sent > 100) begin
          hold_ticket <= hold_ticket + 4'd1;
          hold_done = 1'b1;
        end
        compose_buffer();
        foreach (buf_bytes[i]) begin
          note_q.push_back(NO_NOTE);
          send_byte(buf_bytes[i], i == buf_bytes.size() - 1);
        end
        phase_sent += buf_bytes.size();
      end
      drain_block();
    end

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: handshake_transcript_extractor_core.f
rtl/core/htx_pkg.sv
rtl/core/htx_apb_regs.sv
rtl/core/htx_parser.sv
rtl/core/htx_result_buf.sv
rtl/core/handshake_transcript_extractor_core.sv
bench/tb_handshake_transcript_extractor_core.sv
